// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the Modbus RTU response parser.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg)
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// File: sv/mbrp_pkg.sv
// ----------------------------------------------------------------------------
// mbrp_pkg
// Types, constants and the CRC-16 step shared by the response parser files.
// ----------------------------------------------------------------------------
`default_nettype none

package mbrp_pkg;

	// frame limits
	localparam int MAX_FRAME = 256;
	localparam int POS_W     = $clog2(MAX_FRAME + 1);

	// field widths
	localparam int BYTE_W = 8;
	localparam int FUNC_W = 7;
	localparam int WIDX_W = 11;
	localparam int WORD_W = 16;

	// CRC-16, reflected
	localparam logic [WORD_W-1:0] CRC_INIT = 16'hFFFF;
	localparam logic [WORD_W-1:0] CRC_POLY = 16'hA001;

	// protocol constants
	localparam logic [BYTE_W-1:0] EXC_FLAG      = 8'h80;
	localparam int                MIN_LEN       = 4;
	localparam int                READ_OVERHEAD = 5;
	localparam logic [FUNC_W-1:0] FN_READ_FIRST = 7'd1;
	localparam logic [FUNC_W-1:0] FN_BITS_LAST  = 7'd2;
	localparam logic [FUNC_W-1:0] FN_READ_LAST  = 7'd4;
	localparam int                HDR_LEN       = 3;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_CRC_ERR   = 2'd1,
		ST_FRAME_ERR = 2'd2,
		ST_EXCEPTION = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		REG_SLAVE     = 2'd0,
		REG_FUNCTION  = 2'd1,
		REG_MAX_WORDS = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		DESC_NONE,
		DESC_BITS,
		DESC_WORD,
		DESC_STATUS
	} desc_kind_t;

	typedef struct packed {
		logic [BYTE_W-1:0] slave;
		logic [FUNC_W-1:0] func;
		logic [WIDX_W-1:0] max_words;
	} cfg_t;

	// work handed from the frame checker to the output expander
	typedef struct packed {
		desc_kind_t        kind;
		logic [BYTE_W-1:0] bits;
		logic [3:0]        count;
		logic [WIDX_W-1:0] index;
		logic [WORD_W-1:0] word;
		status_t           status;
		logic [BYTE_W-1:0] exc;
	} desc_t;

	// one byte through the reflected CRC-16
	function automatic logic [WORD_W-1:0] crc16_byte(input logic [WORD_W-1:0] crc,
		input logic [BYTE_W-1:0] b);
		logic [WORD_W-1:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// File: sv/mbrp_chan_if.sv
// ----------------------------------------------------------------------------
// mbrp channel interfaces
// Valid/ready channels for received bytes and for parser result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbrp_in_if import mbrp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;
	logic              end_of_frame;

	modport source(output valid, output rx_byte, output end_of_frame, input ready);
	modport sink(input valid, input rx_byte, input end_of_frame, output ready);
endinterface

interface mbrp_out_if import mbrp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              is_status;
	logic [WIDX_W-1:0] word_index;
	logic [WORD_W-1:0] data_word;
	logic [1:0]        status;
	logic [BYTE_W-1:0] exception_code;
	logic              last_result;

	modport source(output valid, output is_status, output word_index, output data_word,
		output status, output exception_code, output last_result, input ready);
	modport sink(input valid, input is_status, input word_index, input data_word,
		input status, input exception_code, input last_result, output ready);
endinterface

`default_nettype wire

// File: sv/modbus_rtu_response_parser_unit.sv
// ----------------------------------------------------------------------------
// modbus_rtu_response_parser_unit
// Modbus RTU response parser: CRC-16 check, header checks, data extraction.
// ----------------------------------------------------------------------------
//  channel    dir  handshake            payload
//  byte_in    in   valid/ready          rx_byte, end_of_frame
//  item_out   out  valid/ready          is_status, word_index, data_word,
//                                       status, exception_code, last_result
//  cfg        in   cfg_we (no wait)     cfg_index, cfg_wdata
//
// One byte per cycle while each byte yields at most one result item and item_out is ready.
// A coil/input byte yields up to 8 items, one per cycle from the output
// expander while item_out is ready, so the input stalls behind it.
// A byte's first item passes two registers: input register, then expander.
// Reset clears all frame state; item_out stall backs up into byte_in.ready.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module modbus_rtu_response_parser_unit import mbrp_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	mbrp_in_if.sink                byte_in,
	mbrp_out_if.source             item_out,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [WIDX_W-1:0] cfg_wdata
);

	cfg_t              cfg_q;
	desc_t             desc;
	logic              desc_push;
	logic              dn_free;
	logic              advance;

	// output expander
	logic              s2_valid_q;
	logic [2:0]        rem_q;
	logic [6:0]        shift_q;
	logic              is_status_q;
	logic [WIDX_W-1:0] index_q;
	logic [WORD_W-1:0] word_q;
	status_t           status_q;
	logic [BYTE_W-1:0] exc_q;
	logic              last_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slave     <= 8'd1;
			cfg_q.func      <= 7'd3;
			cfg_q.max_words <= 11'd125;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_SLAVE:     cfg_q.slave     <= cfg_wdata[BYTE_W-1:0];
				REG_FUNCTION:  cfg_q.func      <= cfg_wdata[FUNC_W-1:0];
				REG_MAX_WORDS: cfg_q.max_words <= cfg_wdata;
				default: ;
			endcase
		end
	end

	mbrp_frame_check u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.byte_in   (byte_in),
		.dn_free   (dn_free),
		.desc      (desc),
		.desc_push (desc_push)
	);

	// expander is free once its last item goes out
	assign dn_free = !s2_valid_q || (item_out.ready && rem_q == 3'd0);
	assign advance = s2_valid_q && item_out.ready && (rem_q != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
			rem_q      <= '0;
		end else if (desc_push) begin
			s2_valid_q <= 1'b1;
			rem_q      <= (desc.kind == DESC_BITS) ? 3'(desc.count - 4'd1) : 3'd0;
		end else if (advance) begin
			rem_q <= rem_q - 3'd1;
		end else if (item_out.ready) begin
			s2_valid_q <= 1'b0;
		end
	end

	// item payload, shifted out one bit per transaction for coil bytes
	always_ff @(posedge clk) begin
		if (desc_push) begin
			is_status_q <= (desc.kind == DESC_STATUS);
			last_q      <= (desc.kind == DESC_STATUS);
			index_q     <= desc.index;
			word_q      <= desc.word;
			status_q    <= desc.status;
			exc_q       <= desc.exc;
			shift_q     <= desc.bits[7:1];
		end else if (advance) begin
			index_q <= index_q + WIDX_W'(1);
			word_q  <= {15'd0, shift_q[0]};
			shift_q <= shift_q >> 1;
		end
	end

	assign item_out.valid          = s2_valid_q;
	assign item_out.is_status      = is_status_q;
	assign item_out.word_index     = index_q;
	assign item_out.data_word      = word_q;
	assign item_out.status         = status_q;
	assign item_out.exception_code = exc_q;
	assign item_out.last_result    = last_q;

	`ASSERT_IMPLY(a_status_last, clk, arst_n, s2_valid_q, last_q == is_status_q, "status item without last flag")
	`ASSERT_IMPLY(a_burst_data, clk, arst_n, s2_valid_q && rem_q != 3'd0, !is_status_q, "status inside bit burst")
	`ASSERT_NEXT(a_burst_index, clk, arst_n, advance, index_q == $past(index_q) + WIDX_W'(1), "bit index not stepping")

endmodule

`default_nettype wire

// File: sv/mbrp_frame_check.sv
// ----------------------------------------------------------------------------
// mbrp_frame_check
// Input register plus per-frame state: CRC, header capture, byte position.
// Turns each byte into at most one work descriptor for the output expander.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mbrp_frame_check import mbrp_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg,
	mbrp_in_if.sink    byte_in,
	input  wire logic  dn_free,
	output desc_t      desc,
	output logic       desc_push
);

	// input stage
	logic              s1_valid_q;
	logic [BYTE_W-1:0] s1_byte_s1;
	logic              s1_eof_s1;

	// frame state
	logic [WORD_W-1:0] crc_q;
	logic [WORD_W-1:0] crc_prev_q;
	logic [BYTE_W-1:0] prev_byte_q;
	logic [POS_W-1:0]  pos_q;
	logic [BYTE_W-1:0] slave_q;
	logic [BYTE_W-1:0] fc_q;
	logic [BYTE_W-1:0] bc_q;
	logic [BYTE_W-1:0] hold_q;

	logic              go;
	logic              overflow;
	logic [POS_W-1:0]  d;
	logic              read_fn;
	logic              hdr_match;
	logic              data_ok;
	logic [WIDX_W-1:0] base;
	logic [WIDX_W-1:0] room;
	logic [WIDX_W-1:0] reg_idx;
	logic [POS_W:0]    len;
	logic [WORD_W-1:0] recv;
	logic [POS_W:0]    bc_len;

	// byte decode
	always_comb begin
		overflow  = pos_q >= POS_W'(MAX_FRAME);
		d         = pos_q - POS_W'(HDR_LEN);
		read_fn   = (cfg.func >= FN_READ_FIRST) && (cfg.func <= FN_READ_LAST);
		hdr_match = (slave_q == cfg.slave) && (fc_q == {1'b0, cfg.func});
		data_ok   = (pos_q >= POS_W'(HDR_LEN)) && !overflow && !s1_eof_s1 &&
			hdr_match && read_fn && (d < POS_W'(bc_q));
		base      = {d[7:0], 3'b000};
		room      = cfg.max_words - base;
		reg_idx   = {4'b0000, d[7:1]};
		len       = {1'b0, pos_q} + (POS_W+1)'(1);
		recv      = {s1_byte_s1, prev_byte_q};
		bc_len    = (POS_W+1)'(bc_q) + (POS_W+1)'(READ_OVERHEAD);

		desc        = '0;
		desc.kind   = DESC_NONE;
		desc.status = ST_OK;
		if (s1_eof_s1) begin
			desc.kind = DESC_STATUS;
			if (overflow || len < (POS_W+1)'(MIN_LEN)) begin
				desc.status = ST_FRAME_ERR;
			end else if (crc_prev_q != recv) begin
				desc.status = ST_CRC_ERR;
			end else if (slave_q != cfg.slave) begin
				desc.status = ST_FRAME_ERR;
			end else if (fc_q == ({1'b0, cfg.func} | EXC_FLAG)) begin
				desc.status = ST_EXCEPTION;
				if (len >= (POS_W+1)'(READ_OVERHEAD)) begin
					desc.exc = bc_q;
				end
			end else if (fc_q != {1'b0, cfg.func}) begin
				desc.status = ST_FRAME_ERR;
			end else if (read_fn) begin
				if (len < (POS_W+1)'(READ_OVERHEAD) || bc_len != len) begin
					desc.status = ST_FRAME_ERR;
				end
			end
		end else if (data_ok) begin
			if (cfg.func <= FN_BITS_LAST) begin
				// coil / input bits, LSB first, clipped at max_words
				if (base < cfg.max_words) begin
					desc.kind  = DESC_BITS;
					desc.bits  = s1_byte_s1;
					desc.index = base;
					desc.word  = {15'd0, s1_byte_s1[0]};
					desc.count = (room >= WIDX_W'(8)) ? 4'd8 : room[3:0];
				end
			end else if (d[0] && (reg_idx < cfg.max_words)) begin
				// register, big-endian pair
				desc.kind  = DESC_WORD;
				desc.index = reg_idx;
				desc.word  = {hold_q, s1_byte_s1};
			end
		end
	end

	assign go            = s1_valid_q && ((desc.kind == DESC_NONE) || dn_free);
	assign desc_push     = go && (desc.kind != DESC_NONE);
	assign byte_in.ready = !s1_valid_q || go;

	// input register payload
	always_ff @(posedge clk) begin
		if (byte_in.valid && byte_in.ready) begin
			s1_byte_s1 <= byte_in.rx_byte;
			s1_eof_s1  <= byte_in.end_of_frame;
		end
	end

	// input valid and frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			crc_q       <= CRC_INIT;
			crc_prev_q  <= CRC_INIT;
			prev_byte_q <= '0;
			pos_q       <= '0;
			slave_q     <= '0;
			fc_q        <= '0;
			bc_q        <= '0;
			hold_q      <= '0;
		end else begin
			if (byte_in.ready) begin
				s1_valid_q <= byte_in.valid;
			end
			if (go) begin
				if (s1_eof_s1) begin
					crc_q       <= CRC_INIT;
					crc_prev_q  <= CRC_INIT;
					prev_byte_q <= '0;
					pos_q       <= '0;
					slave_q     <= '0;
					fc_q        <= '0;
					bc_q        <= '0;
					hold_q      <= '0;
				end else begin
					crc_q       <= crc16_byte(crc_q, s1_byte_s1);
					crc_prev_q  <= crc_q;
					prev_byte_q <= s1_byte_s1;
					if (!overflow) begin
						pos_q <= pos_q + POS_W'(1);
					end
					if (pos_q == POS_W'(0)) begin
						slave_q <= s1_byte_s1;
					end
					if (pos_q == POS_W'(1)) begin
						fc_q <= s1_byte_s1;
					end
					if (pos_q == POS_W'(2)) begin
						bc_q <= s1_byte_s1;
					end
					// first byte of a register pair
					if (data_ok && !d[0]) begin
						hold_q <= s1_byte_s1;
					end
				end
			end
		end
	end

	`ASSERT_ALWAYS(a_pos_bound, clk, arst_n, pos_q <= POS_W'(MAX_FRAME), "byte position past frame limit")
	`ASSERT_IMPLY(a_eof_status, clk, arst_n, go && s1_eof_s1, desc_push && desc.kind == DESC_STATUS, "frame end without status")
	`ASSERT_NEXT(a_eof_clear, clk, arst_n, go && s1_eof_s1, pos_q == '0 && crc_q == CRC_INIT, "frame state not cleared")

endmodule

`default_nettype wire
